// ===== hw/rtl/itae_pkg.sv =====
// Shared types, constants and the arctangent table of the IMU tilt angle estimator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package itae_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int SAMPLE_WIDTH_DEFAULT  = 16;
   localparam int ATAN_TABLE_LEN        = 24;

   // CORDIC angle accumulator: Q2.30 plus headroom for the half-turn pre-rotation.
   localparam int ANGLE_WIDTH = 35;
   localparam logic signed [ANGLE_WIDTH-1:0] PI_Q30 = 35'sd3373259426;

   // Final tilt clamp in Q3.13, just above pi.
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;

   localparam logic [23:0] GYRO_GAIN_RESET = 24'd11993850;

   typedef struct packed {
      logic valid;
      logic origin;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [31:0] angle;
      logic               sat;
   } gyro_res_type;

   // atan(2^-i) in Q2.30, truncated.
   function automatic logic signed [ANGLE_WIDTH-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANGLE_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 35'sd843314856;
         5'd1:    val = 35'sd497837829;
         5'd2:    val = 35'sd263043836;
         5'd3:    val = 35'sd133525158;
         5'd4:    val = 35'sd67021686;
         5'd5:    val = 35'sd33543515;
         5'd6:    val = 35'sd16775850;
         5'd7:    val = 35'sd8388437;
         5'd8:    val = 35'sd4194282;
         5'd9:    val = 35'sd2097149;
         5'd10:   val = 35'sd1048575;
         5'd11:   val = 35'sd524287;
         5'd12:   val = 35'sd262143;
         5'd13:   val = 35'sd131071;
         5'd14:   val = 35'sd65535;
         5'd15:   val = 35'sd32767;
         5'd16:   val = 35'sd16383;
         5'd17:   val = 35'sd8191;
         5'd18:   val = 35'sd4095;
         5'd19:   val = 35'sd2047;
         5'd20:   val = 35'sd1023;
         5'd21:   val = 35'sd511;
         5'd22:   val = 35'sd255;
         5'd23:   val = 35'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/itae_cell.sv =====
// One rotation cell of the vectoring CORDIC chain; also carries the gyro result along.
// Depends on itae_pkg.
`timescale 1ns / 1ps

module itae_cell
   import itae_pkg::*;
#(
   parameter int                            XW    = SAMPLE_WIDTH_DEFAULT + 12,
   parameter int                            SHIFT = 0,
   parameter logic signed [ANGLE_WIDTH-1:0] ANGLE = '0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cell_ctrl_type                 src_ctrl,
   input  logic signed [XW-1:0]          src_x,
   input  logic signed [XW-1:0]          src_y,
   input  logic signed [ANGLE_WIDTH-1:0] src_z,
   input  gyro_res_type                  src_gyro,
   output cell_ctrl_type                 dst_ctrl,
   output logic signed [XW-1:0]          dst_x,
   output logic signed [XW-1:0]          dst_y,
   output logic signed [ANGLE_WIDTH-1:0] dst_z,
   output gyro_res_type                  dst_gyro
);

   cell_ctrl_type                 ctrl_ff;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   gyro_res_type                  gyro_ff;
   logic signed [XW-1:0]          dx, dy;
   logic                          y_pos;

   always_comb begin
      dx    = src_y >>> SHIFT;
      dy    = src_x >>> SHIFT;
      y_pos = !src_y[XW-1] && (src_y != '0);
      if (y_pos) begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ANGLE;
      end else begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= src_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         gyro_ff <= src_gyro;
      end
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;
   assign dst_gyro = gyro_ff;

endmodule

// ===== hw/rtl/itae_front.sv =====
// Input stage: sign handling, half-plane fold and scaling for the CORDIC, and the
// gyro rate times gain product. Depends on itae_pkg.
`timescale 1ns / 1ps

module itae_front
   import itae_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int XW           = SAMPLE_WIDTH + 12,
   parameter int PW           = SAMPLE_WIDTH + 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          sample_valid,
   input  logic signed [15:0]            accel_y,
   input  logic signed [15:0]            accel_z,
   input  logic signed [15:0]            gyro_rate,
   input  logic [23:0]                   gyro_gain,
   output cell_ctrl_type                 dst_ctrl,
   output logic signed [XW-1:0]          dst_x,
   output logic signed [XW-1:0]          dst_y,
   output logic signed [ANGLE_WIDTH-1:0] dst_z,
   output logic signed [PW-1:0]          dst_prod
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int RW = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

   logic [RW-1:0]                 ay_raw, az_raw, rate_raw;
   logic signed [W-1:0]           ay_s, az_s, rate_s;
   logic signed [W:0]             x0, y0, x_fold, y_fold;
   logic                          left;
   cell_ctrl_type                 ctrl_ff, ctrl_in;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   logic signed [PW-1:0]          prod_ff, prod_in;

   always_comb begin
      // The raw field is zero-extended, then its low bits are read as two's complement.
      ay_raw   = RW'(unsigned'(accel_y));
      az_raw   = RW'(unsigned'(accel_z));
      rate_raw = RW'(unsigned'(gyro_rate));
      ay_s     = signed'(ay_raw[W-1:0]);
      az_s     = signed'(az_raw[W-1:0]);
      rate_s   = signed'(rate_raw[W-1:0]);

      x0   = (W+1)'(ay_s);
      y0   = -((W+1)'(az_s));
      left = x0[W];

      // Left half plane: turn the vector by a half turn and preload the angle.
      x_fold = left ? -x0 : x0;
      y_fold = left ? -y0 : y0;
      if (left) begin
         z_in = y0[W] ? -PI_Q30 : PI_Q30;
      end else begin
         z_in = '0;
      end
      x_in = XW'(x_fold) <<< 8;
      y_in = XW'(y_fold) <<< 8;

      ctrl_in.valid  = sample_valid;
      ctrl_in.origin = (x0 == '0) && (y0 == '0);

      prod_in = PW'(rate_s) * PW'(signed'({1'b0, gyro_gain}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         prod_ff <= prod_in;
      end
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;
   assign dst_prod = prod_ff;

endmodule

// ===== hw/rtl/itae_gyro.sv =====
// Saturating gyro angle accumulator: rounds the rate product to a Q7.24 increment
// and adds it to the running sum. Depends on itae_pkg.
`timescale 1ns / 1ps

module itae_gyro
   import itae_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int PW           = SAMPLE_WIDTH + 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 sample_valid,
   input  logic signed [PW-1:0] prod,
   output gyro_res_type         result
);

   localparam int IW = PW - 16;
   localparam int SW = (IW + 1 > 33) ? IW + 2 : 34;
   localparam logic signed [PW-1:0] HALF_LSB = PW'(32768);
   localparam logic signed [SW-1:0] SUM_MAX  = SW'(2147483647);
   localparam logic signed [SW-1:0] SUM_MIN  = -SUM_MAX - 1;

   logic signed [31:0]   gyro_sum_ff, gyro_sum_in;
   logic signed [PW-1:0] prod_round;
   logic signed [IW-1:0] inc;
   logic signed [SW-1:0] sum_wide;
   logic                 sat;

   always_comb begin
      prod_round = prod + HALF_LSB;
      inc        = IW'(prod_round >>> 16);
      sum_wide   = SW'(gyro_sum_ff) + SW'(inc);
      if (sum_wide > SUM_MAX) begin
         gyro_sum_in = 32'h7FFF_FFFF;
         sat         = 1'b1;
      end else if (sum_wide < SUM_MIN) begin
         gyro_sum_in = 32'h8000_0000;
         sat         = 1'b1;
      end else begin
         gyro_sum_in = 32'(sum_wide);
         sat         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_sum_ff <= '0;
      end else if (advance && sample_valid) begin
         gyro_sum_ff <= gyro_sum_in;
      end
   end

   assign result.angle = gyro_sum_in;
   assign result.sat   = sat;

endmodule

// ===== hw/rtl/imu_tilt_angle_estimator.sv =====
// Top level of the IMU tilt angle estimator: input stage, gyro accumulator,
// CORDIC cell chain and output register. Depends on itae_pkg and all itae_ modules.
`timescale 1ns / 1ps

// Each accepted sample yields one result: the accelerometer tilt atan2(-z, y) in
// Q3.13 radians, from a vectoring CORDIC built as a chain of CORDIC_STAGES
// registered cells, and the running gyro angle in Q7.24 radians with a flag for
// the sample whose addition was clamped. The block takes one sample every cycle;
// a result passes through the input stage register, the register of each cell
// and the output register. When the result is not taken the whole chain
// holds, and req_tready stays low until the output register empties. The gyro
// gain may be rewritten through the csr port only while no sample is in flight.
module imu_tilt_angle_estimator
   import itae_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_y [15:0], accel_z [31:16], gyro_rate [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // accel_angle [15:0], gyro_angle [47:16]
   output logic [0:0]  rsp_tuser    // gyro_saturated [0]
);

   localparam int XW = SAMPLE_WIDTH + 12;
   localparam int PW = SAMPLE_WIDTH + 25;
   localparam int RW = ANGLE_WIDTH - 17;
   localparam int N  = CORDIC_STAGES;
   localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF = ANGLE_WIDTH'(65536);

   logic                          advance;
   logic [23:0]                   gyro_gain_ff;
   cell_ctrl_type                 front_ctrl;
   logic signed [PW-1:0]          front_prod;
   gyro_res_type                  gyro_res;

   cell_ctrl_type                 ctrl_chain [0:N];
   logic signed [XW-1:0]          x_chain    [0:N];
   logic signed [XW-1:0]          y_chain    [0:N];
   logic signed [ANGLE_WIDTH-1:0] z_chain    [0:N];
   gyro_res_type                  gyro_chain [0:N];

   logic signed [ANGLE_WIDTH-1:0] z_round;
   logic signed [RW-1:0]          tilt_wide;
   logic signed [15:0]            accel_angle_in, accel_angle_ff;
   logic signed [31:0]            gyro_angle_ff;
   logic                          gyro_sat_ff;
   logic                          rsp_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_gain_ff <= GYRO_GAIN_RESET;
      end else if (csr_we) begin
         gyro_gain_ff <= csr_wdata;
      end
   end

   itae_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .XW           (XW),
      .PW           (PW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_valid (req_tvalid),
      .accel_y      (signed'(req_tdata[15:0])),
      .accel_z      (signed'(req_tdata[31:16])),
      .gyro_rate    (signed'(req_tdata[47:32])),
      .gyro_gain    (gyro_gain_ff),
      .dst_ctrl     (front_ctrl),
      .dst_x        (x_chain[0]),
      .dst_y        (y_chain[0]),
      .dst_z        (z_chain[0]),
      .dst_prod     (front_prod)
   );

   itae_gyro #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .PW           (PW)
   ) u_gyro (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_valid (front_ctrl.valid),
      .prod         (front_prod),
      .result       (gyro_res)
   );

   assign ctrl_chain[0] = front_ctrl;
   assign gyro_chain[0] = gyro_res;

   for (genvar i = 0; i < N; i++) begin : g_cell
      itae_cell #(
         .XW    (XW),
         .SHIFT (i),
         .ANGLE (atan_q30(5'(i)))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .src_ctrl (ctrl_chain[i]),
         .src_x    (x_chain[i]),
         .src_y    (y_chain[i]),
         .src_z    (z_chain[i]),
         .src_gyro (gyro_chain[i]),
         .dst_ctrl (ctrl_chain[i+1]),
         .dst_x    (x_chain[i+1]),
         .dst_y    (y_chain[i+1]),
         .dst_z    (z_chain[i+1]),
         .dst_gyro (gyro_chain[i+1])
      );
   end

   // Round Q2.30 half up to Q3.13, then clamp to just beyond pi; a vector at the origin gives zero.
   always_comb begin
      z_round   = z_chain[N] + ROUND_HALF;
      tilt_wide = RW'(z_round >>> 17);
      if (ctrl_chain[N].origin) begin
         accel_angle_in = '0;
      end else if (tilt_wide > ANGLE_LIMIT) begin
         accel_angle_in = ANGLE_LIMIT;
      end else if (tilt_wide < -ANGLE_LIMIT) begin
         accel_angle_in = -ANGLE_LIMIT;
      end else begin
         accel_angle_in = 16'(tilt_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctrl_chain[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accel_angle_ff <= accel_angle_in;
         gyro_angle_ff  <= gyro_chain[N].angle;
         gyro_sat_ff    <= gyro_chain[N].sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {gyro_angle_ff, accel_angle_ff};
   assign rsp_tuser  = gyro_sat_ff;

endmodule
